[rtl/core/rat_alu_pkg.sv]
package rat_alu_pkg;

  // Operation codes carried on the opcode field
  localparam logic [2:0] OPC_LOAD = 3'd0;
  localparam logic [2:0] OPC_ADD  = 3'd1;
  localparam logic [2:0] OPC_SUB  = 3'd2;
  localparam logic [2:0] OPC_MUL  = 3'd3;
  localparam logic [2:0] OPC_DIV  = 3'd4;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,   // take the input word
    OP_SETND,     // N <= a, D <= b
    OP_GCDINIT,   // G <= a, T <= b
    OP_ADDSUB,    // N <= N +/- T
    OP_ONE,       // D <= 1
    OP_FIX,       // move sign of D onto N
    OP_COMMIT,    // update accumulator, load result register
    OP_MUL,       // dst <= a * b (iterative)
    OP_QUO,       // dst <= a / b (iterative, truncating)
    OP_REM        // G <= T, T <= G rem T (one Euclid step)
  } op_e;

  // Datapath working registers
  typedef enum logic [2:0] {
    R_AN, R_AD, R_FN, R_FD, R_N, R_D, R_G, R_T
  } reg_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_LOAD,
    S_A_GINIT, S_A_GTEST, S_A_GSTEP,
    S_A_DIV1, S_A_MUL1, S_A_DIV2, S_A_MUL2, S_A_DIV3, S_A_MUL3, S_A_ADDSUB,
    S_M_MULN, S_M_MULD,
    S_R_CHK, S_R_ONE, S_R_GINIT, S_R_GTEST, S_R_GSTEP, S_R_DIVN, S_R_DIVD, S_R_FIX,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic go;
    op_e  op;
    reg_e a;
    reg_e b;
    reg_e dst;
  } cmd_t;

  typedef struct packed {
    logic       done;     // iterative op writes back this cycle
    logic       t_zero;
    logic       n_zero;
    logic       pre_bad;
    logic [2:0] opc;
  } sts_t;

endpackage

[rtl/core/rational_accumulator_alu.sv]
// Rational accumulator: holds a reduced fraction acc_num/acc_den.
// Input channel (in_valid_i / in_stall_o): one word = opcode plus operand
//   fraction; opcode load, add, sub, mul, div (codes above div act as div).
// Output channel (out_valid_o / out_stall_i): one word per input word with
//   the reduced accumulator, an is_whole flag and bad_operand, which is set
//   when the operand (or a wrapped result) would give a zero or negative
//   denominator; the accumulator is then left as it was and reported.
// Flow: one word is worked on at a time. Each multiply, quotient and
//   Euclid remainder step runs on one shared bit-serial engine, and each
//   remainder step is followed by a zero test.
//   A rejected word passes through accept, decode and commit only;
//   mul/div run two engine multiplies plus the reduction; add/sub adds a
//   second GCD and six engine ops.
//   The reduction is k Euclid steps plus two quotients, k at most about 46
//   for 32-bit words; a zero numerator instead just sets the denominator to 1.
// The next word is taken as soon as the result is parked in the output
//   register; a stalled receiver only blocks the block at the next commit.
// Reset (rst_ni, async, active low) gives 0/1 and an empty output register.
module rational_accumulator_alu #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] operand_num_i,
  input  logic signed [31:0] operand_den_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_num_o,
  output logic [30:0]        result_den_o,
  output logic               is_whole_o,
  output logic               bad_operand_o
);

  rat_alu_pkg::cmd_t cmd;
  rat_alu_pkg::sts_t sts;

  // sequencer: walks the micro-op list for each opcode
  rat_alu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // registers, serial mul/div engine and result register
  rat_alu_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .operand_num_i (operand_num_i),
    .operand_den_i (operand_den_i),
    .result_num_o  (result_num_o),
    .result_den_o  (result_den_o),
    .is_whole_o    (is_whole_o),
    .bad_operand_o (bad_operand_o)
  );

endmodule

[rtl/core/rat_alu_dp.sv]
module rat_alu_dp #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rat_alu_pkg::cmd_t   cmd_i,
  output rat_alu_pkg::sts_t   sts_o,
  input  logic [2:0]          opcode_i,
  input  logic signed [31:0]  operand_num_i,
  input  logic signed [31:0]  operand_den_i,
  output logic signed [31:0]  result_num_o,
  output logic [30:0]         result_den_o,
  output logic                is_whole_o,
  output logic                bad_operand_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned CW = $clog2(WORD_BITS);

  function automatic logic [W-1:0] ext_field(input logic [31:0] x);
    logic [W-1:0] r;
    for (int i = 0; i < W; i++) begin
      if (i < 32) r[i] = x[i];
      else        r[i] = x[31];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  logic [W-1:0] an_q, ad_q, fn_q, fd_q, n_q, d_q, g_q, t_q;
  logic [2:0]   opc_q;
  logic         pre_bad_q;

  // iterative engine
  logic                busy_q, fin_q;
  logic [CW-1:0]       cnt_q;
  rat_alu_pkg::op_e    eop_q;
  rat_alu_pkg::reg_e   edst_q;
  logic [W-1:0]        ea_q, eb_q, ep_q, eq_q;
  logic                qneg_q, rneg_q, bz_q;

  logic [W-1:0] va, vb, fn_x, fd_x;
  logic [W:0]   trial;
  logic [W-1:0] quo, rem;
  logic         eng_go, commit_go, commit_ok;
  logic [W-1:0] acc_n, acc_d;

  always_comb begin
    unique case (cmd_i.a)
      rat_alu_pkg::R_AN: va = an_q;
      rat_alu_pkg::R_AD: va = ad_q;
      rat_alu_pkg::R_FN: va = fn_q;
      rat_alu_pkg::R_FD: va = fd_q;
      rat_alu_pkg::R_N:  va = n_q;
      rat_alu_pkg::R_D:  va = d_q;
      rat_alu_pkg::R_G:  va = g_q;
      default:           va = t_q;
    endcase
    unique case (cmd_i.b)
      rat_alu_pkg::R_AN: vb = an_q;
      rat_alu_pkg::R_AD: vb = ad_q;
      rat_alu_pkg::R_FN: vb = fn_q;
      rat_alu_pkg::R_FD: vb = fd_q;
      rat_alu_pkg::R_N:  vb = n_q;
      rat_alu_pkg::R_D:  vb = d_q;
      rat_alu_pkg::R_G:  vb = g_q;
      default:           vb = t_q;
    endcase
  end

  assign fn_x = ext_field(operand_num_i);
  assign fd_x = ext_field(operand_den_i);

  assign eng_go = cmd_i.go && (cmd_i.op == rat_alu_pkg::OP_MUL ||
                               cmd_i.op == rat_alu_pkg::OP_QUO ||
                               cmd_i.op == rat_alu_pkg::OP_REM);

  // restoring divide step on magnitudes
  assign trial = {ep_q, ea_q[W-1]} - {1'b0, eb_q};
  assign quo   = bz_q ? '0 : (qneg_q ? (~eq_q + W'(1)) : eq_q);
  assign rem   = bz_q ? '0 : (rneg_q ? (~ep_q + W'(1)) : ep_q);

  assign commit_go = cmd_i.go && cmd_i.op == rat_alu_pkg::OP_COMMIT;
  assign commit_ok = !pre_bad_q && d_q != '0 && !d_q[W-1];
  assign acc_n     = commit_ok ? n_q : an_q;
  assign acc_d     = commit_ok ? d_q : ad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
      an_q   <= '0;
      ad_q   <= W'(1);
    end else begin
      fin_q <= 1'b0;
      if (eng_go) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (commit_go && commit_ok) begin
        an_q <= n_q;
        ad_q <= d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      case (cmd_i.op)
        rat_alu_pkg::OP_CAPTURE: begin
          fn_q      <= fn_x;
          fd_q      <= fd_x;
          opc_q     <= opcode_i;
          pre_bad_q <= (fd_x == '0) || (opcode_i >= rat_alu_pkg::OPC_DIV && fn_x == '0);
        end
        rat_alu_pkg::OP_SETND: begin
          n_q <= va;
          d_q <= vb;
        end
        rat_alu_pkg::OP_GCDINIT: begin
          g_q <= va;
          t_q <= vb;
        end
        rat_alu_pkg::OP_ADDSUB: n_q <= (opc_q == rat_alu_pkg::OPC_SUB) ? n_q - t_q : n_q + t_q;
        rat_alu_pkg::OP_ONE:    d_q <= W'(1);
        rat_alu_pkg::OP_FIX: begin
          if (d_q[W-1]) begin
            d_q <= ~d_q + W'(1);
            n_q <= ~n_q + W'(1);
          end
        end
        rat_alu_pkg::OP_COMMIT: begin
          for (int i = 0; i < 32; i++) begin
            if (i < W) result_num_o[i] <= acc_n[i];
            else       result_num_o[i] <= acc_n[W-1];
          end
          for (int i = 0; i < 31; i++) begin
            if (i < W) result_den_o[i] <= acc_d[i];
            else       result_den_o[i] <= 1'b0;
          end
          is_whole_o    <= (acc_d == W'(1));
          bad_operand_o <= !commit_ok;
        end
        rat_alu_pkg::OP_MUL: begin
          eop_q  <= cmd_i.op;
          edst_q <= cmd_i.dst;
          ea_q   <= va;
          eb_q   <= vb;
          ep_q   <= '0;
        end
        rat_alu_pkg::OP_QUO, rat_alu_pkg::OP_REM: begin
          eop_q  <= cmd_i.op;
          edst_q <= cmd_i.dst;
          ea_q   <= mag(va);
          eb_q   <= mag(vb);
          ep_q   <= '0;
          eq_q   <= '0;
          qneg_q <= va[W-1] ^ vb[W-1];
          rneg_q <= va[W-1];
          bz_q   <= (vb == '0);
        end
        default: ;
      endcase
    end else if (busy_q) begin
      if (eop_q == rat_alu_pkg::OP_MUL) begin
        if (eb_q[0]) ep_q <= ep_q + ea_q;
        ea_q <= {ea_q[W-2:0], 1'b0};
        eb_q <= {1'b0, eb_q[W-1:1]};
      end else begin
        if (!trial[W]) begin
          ep_q <= trial[W-1:0];
          eq_q <= {eq_q[W-2:0], 1'b1};
        end else begin
          ep_q <= {ep_q[W-2:0], ea_q[W-1]};
          eq_q <= {eq_q[W-2:0], 1'b0};
        end
        ea_q <= {ea_q[W-2:0], 1'b0};
      end
    end else if (fin_q) begin
      if (eop_q == rat_alu_pkg::OP_REM) begin
        g_q <= t_q;
        t_q <= rem;
      end else begin
        case (edst_q)
          rat_alu_pkg::R_N: n_q <= (eop_q == rat_alu_pkg::OP_MUL) ? ep_q : quo;
          rat_alu_pkg::R_D: d_q <= (eop_q == rat_alu_pkg::OP_MUL) ? ep_q : quo;
          rat_alu_pkg::R_T: t_q <= (eop_q == rat_alu_pkg::OP_MUL) ? ep_q : quo;
          default: ;
        endcase
      end
    end
  end

  assign sts_o.done    = fin_q;
  assign sts_o.t_zero  = (t_q == '0);
  assign sts_o.n_zero  = (n_q == '0);
  assign sts_o.pre_bad = pre_bad_q;
  assign sts_o.opc     = opc_q;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_go |-> !busy_q && !fin_q)
    else $error("engine started while busy");
  a_den_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ad_q != '0 && !ad_q[W-1])
    else $error("accumulator denominator not positive");
  a_fin_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> $past(busy_q))
    else $error("write-back without iteration");
`endif

endmodule

[rtl/core/rat_alu_ctrl.sv]
module rat_alu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  rat_alu_pkg::sts_t sts_i,
  output rat_alu_pkg::cmd_t cmd_o
);

  rat_alu_pkg::state_e state_q, state_d;
  logic issued_q, issued_d;
  logic out_valid_q, out_valid_d;
  logic is_eng, slot_free, is_mul;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign is_mul    = (sts_i.opc == rat_alu_pkg::OPC_MUL);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rat_alu_pkg::S_IDLE:   if (in_valid_i) state_d = rat_alu_pkg::S_DECODE;
      rat_alu_pkg::S_DECODE: begin
        if (sts_i.pre_bad) state_d = rat_alu_pkg::S_COMMIT;
        else begin
          unique case (sts_i.opc) inside
            rat_alu_pkg::OPC_LOAD:                  state_d = rat_alu_pkg::S_LOAD;
            rat_alu_pkg::OPC_ADD, rat_alu_pkg::OPC_SUB: state_d = rat_alu_pkg::S_A_GINIT;
            default:                                state_d = rat_alu_pkg::S_M_MULN;
          endcase
        end
      end
      rat_alu_pkg::S_LOAD:     state_d = rat_alu_pkg::S_R_CHK;
      rat_alu_pkg::S_A_GINIT:  state_d = rat_alu_pkg::S_A_GTEST;
      rat_alu_pkg::S_A_GTEST:
        state_d = sts_i.t_zero ? rat_alu_pkg::S_A_DIV1 : rat_alu_pkg::S_A_GSTEP;
      rat_alu_pkg::S_A_GSTEP:  if (sts_i.done) state_d = rat_alu_pkg::S_A_GTEST;
      rat_alu_pkg::S_A_DIV1:   if (sts_i.done) state_d = rat_alu_pkg::S_A_MUL1;
      rat_alu_pkg::S_A_MUL1:   if (sts_i.done) state_d = rat_alu_pkg::S_A_DIV2;
      rat_alu_pkg::S_A_DIV2:   if (sts_i.done) state_d = rat_alu_pkg::S_A_MUL2;
      rat_alu_pkg::S_A_MUL2:   if (sts_i.done) state_d = rat_alu_pkg::S_A_DIV3;
      rat_alu_pkg::S_A_DIV3:   if (sts_i.done) state_d = rat_alu_pkg::S_A_MUL3;
      rat_alu_pkg::S_A_MUL3:   if (sts_i.done) state_d = rat_alu_pkg::S_A_ADDSUB;
      rat_alu_pkg::S_A_ADDSUB: state_d = rat_alu_pkg::S_R_CHK;
      rat_alu_pkg::S_M_MULN:   if (sts_i.done) state_d = rat_alu_pkg::S_M_MULD;
      rat_alu_pkg::S_M_MULD:   if (sts_i.done) state_d = rat_alu_pkg::S_R_CHK;
      rat_alu_pkg::S_R_CHK:
        state_d = sts_i.n_zero ? rat_alu_pkg::S_R_ONE : rat_alu_pkg::S_R_GINIT;
      rat_alu_pkg::S_R_ONE:    state_d = rat_alu_pkg::S_COMMIT;
      rat_alu_pkg::S_R_GINIT:  state_d = rat_alu_pkg::S_R_GTEST;
      rat_alu_pkg::S_R_GTEST:
        state_d = sts_i.t_zero ? rat_alu_pkg::S_R_DIVN : rat_alu_pkg::S_R_GSTEP;
      rat_alu_pkg::S_R_GSTEP:  if (sts_i.done) state_d = rat_alu_pkg::S_R_GTEST;
      rat_alu_pkg::S_R_DIVN:   if (sts_i.done) state_d = rat_alu_pkg::S_R_DIVD;
      rat_alu_pkg::S_R_DIVD:   if (sts_i.done) state_d = rat_alu_pkg::S_R_FIX;
      rat_alu_pkg::S_R_FIX:    state_d = rat_alu_pkg::S_COMMIT;
      rat_alu_pkg::S_COMMIT:   if (slot_free) state_d = rat_alu_pkg::S_IDLE;
      default:                 state_d = rat_alu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.go  = 1'b0;
    cmd_o.op  = rat_alu_pkg::OP_NONE;
    cmd_o.a   = rat_alu_pkg::R_N;
    cmd_o.b   = rat_alu_pkg::R_D;
    cmd_o.dst = rat_alu_pkg::R_N;
    is_eng    = 1'b0;
    unique case (state_q)
      rat_alu_pkg::S_IDLE: begin
        cmd_o.op = rat_alu_pkg::OP_CAPTURE;
        cmd_o.go = in_valid_i;
      end
      rat_alu_pkg::S_LOAD: begin
        cmd_o = '{1'b1, rat_alu_pkg::OP_SETND, rat_alu_pkg::R_FN, rat_alu_pkg::R_FD,
                  rat_alu_pkg::R_N};
      end
      rat_alu_pkg::S_A_GINIT: begin
        cmd_o = '{1'b1, rat_alu_pkg::OP_GCDINIT, rat_alu_pkg::R_AD, rat_alu_pkg::R_FD,
                  rat_alu_pkg::R_G};
      end
      rat_alu_pkg::S_A_GSTEP, rat_alu_pkg::S_R_GSTEP: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_REM, rat_alu_pkg::R_G, rat_alu_pkg::R_T,
                   rat_alu_pkg::R_T};
      end
      rat_alu_pkg::S_A_DIV1: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_QUO, rat_alu_pkg::R_AD, rat_alu_pkg::R_G,
                   rat_alu_pkg::R_T};
      end
      rat_alu_pkg::S_A_MUL1: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_MUL, rat_alu_pkg::R_T, rat_alu_pkg::R_FD,
                   rat_alu_pkg::R_D};
      end
      rat_alu_pkg::S_A_DIV2: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_QUO, rat_alu_pkg::R_D, rat_alu_pkg::R_AD,
                   rat_alu_pkg::R_T};
      end
      rat_alu_pkg::S_A_MUL2: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_MUL, rat_alu_pkg::R_T, rat_alu_pkg::R_AN,
                   rat_alu_pkg::R_N};
      end
      rat_alu_pkg::S_A_DIV3: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_QUO, rat_alu_pkg::R_D, rat_alu_pkg::R_FD,
                   rat_alu_pkg::R_T};
      end
      rat_alu_pkg::S_A_MUL3: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_MUL, rat_alu_pkg::R_T, rat_alu_pkg::R_FN,
                   rat_alu_pkg::R_T};
      end
      rat_alu_pkg::S_A_ADDSUB: begin
        cmd_o.go = 1'b1;
        cmd_o.op = rat_alu_pkg::OP_ADDSUB;
      end
      rat_alu_pkg::S_M_MULN: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_MUL, rat_alu_pkg::R_AN,
                   is_mul ? rat_alu_pkg::R_FN : rat_alu_pkg::R_FD, rat_alu_pkg::R_N};
      end
      rat_alu_pkg::S_M_MULD: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_MUL, rat_alu_pkg::R_AD,
                   is_mul ? rat_alu_pkg::R_FD : rat_alu_pkg::R_FN, rat_alu_pkg::R_D};
      end
      rat_alu_pkg::S_R_ONE: begin
        cmd_o.go = 1'b1;
        cmd_o.op = rat_alu_pkg::OP_ONE;
      end
      rat_alu_pkg::S_R_GINIT: begin
        cmd_o = '{1'b1, rat_alu_pkg::OP_GCDINIT, rat_alu_pkg::R_N, rat_alu_pkg::R_D,
                  rat_alu_pkg::R_G};
      end
      rat_alu_pkg::S_R_DIVN: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_QUO, rat_alu_pkg::R_N, rat_alu_pkg::R_G,
                   rat_alu_pkg::R_N};
      end
      rat_alu_pkg::S_R_DIVD: begin
        is_eng = 1'b1;
        cmd_o  = '{1'b0, rat_alu_pkg::OP_QUO, rat_alu_pkg::R_D, rat_alu_pkg::R_G,
                   rat_alu_pkg::R_D};
      end
      rat_alu_pkg::S_R_FIX: begin
        cmd_o.go = 1'b1;
        cmd_o.op = rat_alu_pkg::OP_FIX;
      end
      rat_alu_pkg::S_COMMIT: begin
        cmd_o.go = slot_free;
        cmd_o.op = rat_alu_pkg::OP_COMMIT;
      end
      default: ;
    endcase
    if (is_eng) cmd_o.go = !issued_q;
  end

  always_comb begin
    issued_d = issued_q;
    if (is_eng && !issued_q) issued_d = 1'b1;
    if (sts_i.done)          issued_d = 1'b0;
    out_valid_d = out_valid_q;
    if (!out_stall_i) out_valid_d = 1'b0;
    if (state_q == rat_alu_pkg::S_COMMIT && slot_free) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rat_alu_pkg::S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != rat_alu_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> issued_q)
    else $error("write-back without an issued operation");
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rat_alu_pkg::S_IDLE |-> !issued_q)
    else $error("operation pending in idle");
  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rat_alu_pkg::S_COMMIT && slot_free |=> out_valid_q)
    else $error("commit did not present a word");
`endif

endmodule

[tb/tb_top.sv]
module tb_top;

  // Output word as predicted for one input word
  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               whole;
    logic               bad;
  } frac_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         opcode_i;
  logic signed [31:0] operand_num_i;
  logic signed [31:0] operand_den_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] result_num_o;
  logic [30:0]        result_den_o;
  logic               is_whole_o;
  logic               bad_operand_o;

  rational_accumulator_alu u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .operand_num_i (operand_num_i),
    .operand_den_i (operand_den_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_num_o  (result_num_o),
    .result_den_o  (result_den_o),
    .is_whole_o    (is_whole_o),
    .bad_operand_o (bad_operand_o)
  );

  // Predictor state: the running fraction
  logic [31:0] frac_num;
  logic [31:0] frac_den;
  frac_res_t   pending_q[$];

  int          errors;
  longint      cycle_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;   // long receiver hold-off, counted down below

  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  // ---------------------------------------------------------------
  // 32-bit wrapping helpers, truncating division
  // ---------------------------------------------------------------
  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic logic [31:0] quo32(logic [31:0] a, logic [31:0] b);
    logic [31:0] mb, q;
    mb = mag32(b);
    if (mb == 0) return 32'd0;
    q = mag32(a) / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] rem32(logic [31:0] a, logic [31:0] b);
    logic [31:0] mb, r;
    mb = mag32(b);
    if (mb == 0) return 32'd0;
    r = mag32(a) % mb;
    return a[31] ? -r : r;
  endfunction

  function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    while (b != 0) begin
      r = rem32(a, b);
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Apply one word to the running fraction and return the reported result
  function automatic frac_res_t apply_frac_op(logic [2:0] opc, logic [31:0] fn,
                                              logic [31:0] fd);
    logic [31:0] n, d, g, a, b;
    logic        bad;
    frac_res_t   r;
    bad = 1'b0;
    n = '0;
    d = '0;
    // zero denominator, or any divide-class code with a zero numerator
    if (fd == 0 || (opc >= rat_alu_pkg::OPC_DIV && fn == 0)) begin
      bad = 1'b1;
    end else begin
      case (opc)
        rat_alu_pkg::OPC_LOAD: begin
          n = fn;
          d = fd;
        end
        rat_alu_pkg::OPC_ADD, rat_alu_pkg::OPC_SUB: begin
          d = quo32(frac_den, gcd32(frac_den, fd)) * fd;
          a = quo32(d, frac_den) * frac_num;
          b = quo32(d, fd) * fn;
          n = (opc == rat_alu_pkg::OPC_ADD) ? a + b : a - b;
        end
        rat_alu_pkg::OPC_MUL: begin
          n = frac_num * fn;
          d = frac_den * fd;
        end
        default: begin
          n = frac_num * fd;
          d = frac_den * fn;
        end
      endcase
      if (n == 0) begin
        d = 32'd1;
      end else begin
        g = gcd32(n, d);
        n = quo32(n, g);
        d = quo32(d, g);
        if (d[31]) begin
          d = -d;
          n = -n;
        end
      end
      // wrapped denominator still zero or negative: reject
      if (d == 0 || d[31]) bad = 1'b1;
      else begin
        frac_num = n;
        frac_den = d;
      end
    end
    r.num   = frac_num;
    r.den   = frac_den[30:0];
    r.whole = (frac_den == 1);
    r.bad   = bad;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Clock, reset, cycle limit
  // ---------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Receiver: random stall plus an optional long hold-off
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // Result checker: sampled at the edge, compared with oldest expectation
  always @(posedge clk_i) begin
    frac_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected word num=%0d den=%0d", $time, result_num_o,
                 result_den_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (result_num_o !== exp_r.num) begin
          $display("%0t num exp=%0d got=%0d", $time, exp_r.num, result_num_o);
          errors++;
        end
        if (result_den_o !== exp_r.den) begin
          $display("%0t den exp=%0d got=%0d", $time, exp_r.den, result_den_o);
          errors++;
        end
        if (is_whole_o !== exp_r.whole) begin
          $display("%0t whole exp=%0b got=%0b", $time, exp_r.whole, is_whole_o);
          errors++;
        end
        if (bad_operand_o !== exp_r.bad) begin
          $display("%0t bad exp=%0b got=%0b", $time, exp_r.bad, bad_operand_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------
  // valid stays high after an accept so words can follow back to back;
  // it drops only in an idle cycle or when waiting for the results
  task automatic send_word(logic [2:0] opc, logic [31:0] fn, logic [31:0] fd);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= opc;
    operand_num_i <= fn;
    operand_den_i <= fd;
    pending_q.push_back(apply_frac_op(opc, fn, fd));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // mostly small values so the fraction stays meaningful, some full range
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return $urandom_range(40, 0) - 20;
      2: return $urandom_range(2000, 0) - 1000;
      default: return $urandom_range(10, 1) * (($urandom_range(1, 0)) ? 1 : -1);
    endcase
  endfunction

  function automatic logic [2:0] rand_opcode();
    if ($urandom_range(19, 0) == 0) return 3'($urandom_range(7, 5));
    return 3'($urandom_range(4, 0));
  endfunction

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_directed();
    send_word(rat_alu_pkg::OPC_ADD, 32'sd1, 32'sd2);    // add onto reset value 0/1
    send_word(rat_alu_pkg::OPC_LOAD, 32'sd6, -32'sd4);  // sign moves to numerator
    send_word(rat_alu_pkg::OPC_ADD, 32'sd1, 32'sd6);
    send_word(rat_alu_pkg::OPC_SUB, 32'sd5, 32'sd3);
    send_word(rat_alu_pkg::OPC_MUL, -32'sd3, 32'sd7);
    send_word(rat_alu_pkg::OPC_DIV, 32'sd2, -32'sd9);
    send_word(rat_alu_pkg::OPC_LOAD, 32'sd0, 32'sd5);   // zero gives 0/1
    send_word(rat_alu_pkg::OPC_LOAD, 32'sd3, 32'sd0);   // zero denominator
    send_word(rat_alu_pkg::OPC_DIV, 32'sd0, 32'sd1);    // divide by zero
    send_word(3'd5, 32'sd3, 32'sd2);             // unused codes act as divide
    send_word(3'd7, 32'sd0, 32'sd2);
    send_word(3'd6, -32'sd1, 32'sd1);
    send_word(rat_alu_pkg::OPC_LOAD, 32'h8000_0000, 32'sd1);  // most negative word
    send_word(rat_alu_pkg::OPC_DIV, -32'sd1, 32'sd1);   // most negative / -1 wraps
    send_word(rat_alu_pkg::OPC_LOAD, 32'sd1, 32'h8000_0000);  // den cannot be negated
    send_word(rat_alu_pkg::OPC_LOAD, 32'h7fff_ffff, 32'h7fff_fffe);
    send_word(rat_alu_pkg::OPC_MUL, 32'h7fff_ffff, 32'h7fff_ffff);   // wrapping products
    send_word(rat_alu_pkg::OPC_ADD, 32'h8000_0001, 32'h7fff_fffd);
    send_word(rat_alu_pkg::OPC_LOAD, 32'hffff_ffff, 32'hffff_ffff);
    send_word(rat_alu_pkg::OPC_SUB, 32'h7fff_ffff, 32'h8000_0000);
    send_word(rat_alu_pkg::OPC_LOAD, 32'sd1, 32'sd65536);
    send_word(rat_alu_pkg::OPC_MUL, 32'sd1, 32'sd65536);  // denominator wraps to zero
  endtask

  task automatic test_random(int count);
    repeat (count) send_word(rand_opcode(), rand_operand(), rand_operand());
  endtask

  task automatic test_backpressure();
    hold_cycles = 20000;
    repeat (6) send_word(rand_opcode(), rand_operand(), rand_operand());
    wait_drained();   // sender pauses until every word is back
    repeat (4) send_word(rand_opcode(), rand_operand(), rand_operand());
  endtask

  initial begin
    in_valid_i     = 1'b0;
    opcode_i       = '0;
    operand_num_i  = '0;
    operand_den_i  = '0;
    out_stall_i    = 1'b0;
    errors         = 0;
    cycle_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    frac_num       = 32'd0;
    frac_den       = 32'd1;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    test_directed();
    test_random(250);
    send_idle_pct = 73;
    test_random(200);
    send_idle_pct = 0;
    recv_stall_pct = 73;
    test_random(200);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_random(250);
    recv_stall_pct = 0;
    send_idle_pct = 0;
    test_backpressure();

    wait_drained();
    repeat (5000) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
